/* hw/rtl/swa_pkg.sv */
// Shared types and constants for the sliding window average block.
// No dependencies; imported by swa_intf, swa_div and sliding_window_average.
package swa_pkg;

    localparam int SAMPLE_W = 16;
    localparam int AVG_W    = 16;
    localparam int WIN_W    = 6;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_SUB,
        ST_ADD,
        ST_DIV,
        ST_HOLD
    } state_t;

endpackage

/* hw/rtl/swa_intf.sv */
// Valid/ready channel interfaces for samples, averages and the window register.
// Depends on swa_pkg for field widths.
interface swa_in_if import swa_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       start_series;

    modport source (output valid, output sample, output start_series, input ready);
    modport sink   (input valid, input sample, input start_series, output ready);
endinterface

interface swa_out_if import swa_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [AVG_W-1:0] average;

    modport source (output valid, output average, input ready);
    modport sink   (input valid, input average, output ready);
endinterface

interface swa_cfg_if import swa_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [WIN_W-1:0] window_size;

    modport source (output valid, output window_size, input ready);
    modport sink   (input valid, input window_size, output ready);
endinterface

/* hw/rtl/swa_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module swa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* hw/rtl/swa_div.sv */
// Bit-serial signed divider: window sum by window size, truncating toward zero.
// One quotient bit per cycle through a shift register; depends on swa_pkg.
module swa_div import swa_pkg::*; #(
    parameter int SUM_W = 21
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [SUM_W-1:0] dividend,
    input  logic [WIN_W-1:0]        divisor,
    output logic                    done,
    output logic signed [AVG_W-1:0] quotient
);

    localparam int CNT_W = $clog2(SUM_W + 1);

    logic [SUM_W-1:0] shift_reg;
    logic [WIN_W-1:0] rem_reg;
    logic [WIN_W-1:0] dvs_reg;
    logic             neg_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             run_reg;
    logic             done_reg;

    logic [WIN_W:0]   trial;
    logic [WIN_W:0]   trial_diff;
    logic             ge;
    logic [AVG_W-1:0] mag;

    assign trial      = {rem_reg, shift_reg[SUM_W-1]};
    assign trial_diff = trial - {1'b0, dvs_reg};
    assign ge         = (trial >= {1'b0, dvs_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= run_reg && (cnt_reg == CNT_W'(1));
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= CNT_W'(SUM_W);
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    run_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            shift_reg <= dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
            neg_reg   <= dividend[SUM_W-1];
            rem_reg   <= '0;
            dvs_reg   <= divisor;
        end
        else if (run_reg)
        begin
            shift_reg <= {shift_reg[SUM_W-2:0], ge};
            rem_reg   <= ge ? trial_diff[WIN_W-1:0] : trial[WIN_W-1:0];
        end
    end

    assign mag      = shift_reg[AVG_W-1:0];
    assign quotient = neg_reg ? $signed(-mag) : $signed(mag);
    assign done     = done_reg;

endmodule

/* hw/rtl/sliding_window_average.sv */
// Sliding window average: sample ring, running sum, bit-serial divide.
// Depends on swa_pkg, swa_intf, swa_ram and swa_div.
//
//  channel   dir  payload                          request taken when
//  samples   in   sample[15:0] s, start_series     valid && ready
//  averages  out  average[15:0] s                  valid && ready
//  cfg       in   window_size[5:0]                 valid && ready
//
// A request passes ST_READ, ST_SUB and ST_ADD for the ring read and sum update,
// then ST_DIV while the one-bit-per-cycle divider runs. A request that completes
// no window returns to ST_IDLE from ST_ADD. Reset empties the window.
// A finished average waits in the output register; the next request proceeds
// and its result holds in the divider until the output register frees up.
// Hold a window write until the block is idle; it goes ahead of a waiting sample.
module sliding_window_average import swa_pkg::*; #(
    parameter int WINDOW_MAX = 32
) (
    input  logic         clk,
    input  logic         rst_n,
    swa_in_if.sink       samples,
    swa_out_if.source    averages,
    swa_cfg_if.sink      cfg
);

    localparam int AW    = $clog2(WINDOW_MAX);
    localparam int SUM_W = SAMPLE_W + AW;
    localparam int PD_W  = ((AW > WIN_W) ? AW : WIN_W) + 2;

    state_t state_reg;
    state_t state_next;

    logic [WIN_W-1:0]          window_size_reg;
    logic [WIN_W-1:0]          fill_reg;
    logic signed [SUM_W-1:0]   sum_reg;
    logic [AW-1:0]             pos_reg;
    logic                      out_valid_reg;
    logic signed [AVG_W-1:0]   average_reg;
    logic signed [SAMPLE_W-1:0] sample_reg;
    logic                      start_reg;
    logic                      full_reg;

    logic [WIN_W-1:0]          w_eff;
    logic signed [PD_W-1:0]    pos_diff;
    logic [AW-1:0]             old_idx;
    logic [AW-1:0]             pos_inc;
    logic [WIN_W-1:0]          fill_eff;
    logic [SAMPLE_W-1:0]       ram_rdata;
    logic signed [SUM_W-1:0]   old_ext;
    logic signed [SUM_W-1:0]   new_ext;
    logic signed [SUM_W-1:0]   sum_add;
    logic                      due;
    logic                      slot_free;
    logic                      div_start;
    logic                      div_done;
    logic signed [AVG_W-1:0]   div_q;
    logic                      ram_we;
    logic                      in_take;
    logic                      out_load;

    function automatic logic [WIN_W-1:0] cfg_window_eff(input logic [WIN_W-1:0] w);
        logic [WIN_W-1:0] r;
        r = w;
        if (w == '0)
        begin
            r = WIN_W'(1);
        end
        else if (int'(w) > WINDOW_MAX)
        begin
            r = WIN_W'(WINDOW_MAX);
        end
        return r;
    endfunction

    always_comb
    begin
        w_eff = cfg_window_eff(window_size_reg);
    end

    assign pos_diff = PD_W'(pos_reg) - PD_W'(w_eff);
    assign old_idx  = pos_diff[PD_W-1] ? AW'(pos_diff + PD_W'(WINDOW_MAX)) : AW'(pos_diff);
    assign pos_inc  = (pos_reg == AW'(WINDOW_MAX - 1)) ? '0 : pos_reg + AW'(1);
    assign fill_eff = start_reg ? '0 : fill_reg;

    assign old_ext  = {{(SUM_W-SAMPLE_W){ram_rdata[SAMPLE_W-1]}}, ram_rdata};
    assign new_ext  = {{(SUM_W-SAMPLE_W){sample_reg[SAMPLE_W-1]}}, sample_reg};
    assign sum_add  = sum_reg + new_ext;
    assign due      = full_reg || ((fill_reg + WIN_W'(1)) == w_eff);

    assign slot_free = !out_valid_reg || averages.ready;

    swa_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (WINDOW_MAX)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (pos_reg),
        .wdata (sample_reg),
        .raddr (old_idx),
        .rdata (ram_rdata)
    );

    swa_div #(
        .SUM_W (SUM_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_add),
        .divisor  (w_eff),
        .done     (div_done),
        .quotient (div_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_take    = 1'b0;
        ram_we     = 1'b0;
        div_start  = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_take = samples.valid && samples.ready;
                if (in_take)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_SUB;
            end
            ST_SUB:
            begin
                ram_we     = 1'b1;
                state_next = ST_ADD;
            end
            ST_ADD:
            begin
                div_start  = due;
                state_next = due ? ST_DIV : ST_IDLE;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (slot_free)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign samples.ready    = (state_reg == ST_IDLE) && !cfg.valid;
    assign cfg.ready        = (state_reg == ST_IDLE);
    assign averages.valid   = out_valid_reg;
    assign averages.average = average_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_size_reg <= WIN_W'(1);
            fill_reg        <= '0;
            sum_reg         <= '0;
            pos_reg         <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (averages.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cfg.valid && cfg.ready)
            begin
                window_size_reg <= cfg.window_size;
                fill_reg        <= '0;
                sum_reg         <= '0;
            end
            else
            begin
                case (state_reg)
                    ST_READ:
                    begin
                        fill_reg <= fill_eff;
                        if (start_reg)
                        begin
                            sum_reg <= '0;
                        end
                    end
                    ST_SUB:
                    begin
                        if (full_reg)
                        begin
                            sum_reg <= sum_reg - old_ext;
                        end
                        pos_reg <= pos_inc;
                    end
                    ST_ADD:
                    begin
                        sum_reg  <= sum_add;
                        fill_reg <= full_reg ? w_eff : fill_reg + WIN_W'(1);
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            sample_reg <= samples.sample;
            start_reg  <= samples.start_series;
        end
        if (state_reg == ST_READ)
        begin
            full_reg <= (fill_eff >= w_eff);
        end
        if (out_load)
        begin
            average_reg <= div_q;
        end
    end

endmodule
